### rtl/pcm_sound_chip_16_voice_core_defines.svh
// assertion helpers for the rtl
`ifndef PCM_SOUND_CHIP_16_VOICE_CORE_DEFINES_SVH
`define PCM_SOUND_CHIP_16_VOICE_CORE_DEFINES_SVH

// clocked check, off while in reset
`define PCM16_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define PCM16_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/pcm16_pkg.sv
package pcm16_pkg;

  localparam int MODE_W = 3;
  localparam int REG_W  = 8;
  localparam int DATA_W = 8;
  localparam int RADDR_W = 16;
  localparam int SMP_W  = 16;
  localparam int MASK_W = 16;

  localparam logic [MODE_W-1:0] MODE_REG_WR = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REG_RD = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SAMPLE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CLOCK  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RAM_WR = 3'd4;

  localparam logic [REG_W-1:0] REG_PERIOD_LO = 8'h11;
  localparam logic [REG_W-1:0] REG_PERIOD_HI = 8'h12;
  localparam logic [REG_W-1:0] REG_TIMER     = 8'h14;
  localparam logic [REG_W-1:0] REG_STREAM    = 8'h16;
  localparam logic [REG_W-1:0] REG_KEY       = 8'h17;

  localparam logic [3:0] GRP_PITCH_LO = 4'h2;
  localparam logic [3:0] GRP_PITCH_HI = 4'h3;
  localparam logic [3:0] GRP_LENGTH   = 4'h5;
  localparam logic [3:0] GRP_START_HI = 4'h6;
  localparam logic [3:0] GRP_START_LO = 4'h7;
  localparam logic [3:0] GRP_STREAM   = 4'h9;
  localparam logic [3:0] GRP_VOLUME   = 4'hE;

  typedef struct packed {
    logic [15:0] pitch;
    logic [13:0] length;
    logic [15:0] start;
    logic [15:0] pos;
    logic [15:0] end_addr;
    logic [15:0] frac;
    logic        streaming;
    logic [7:0]  gain_l;
    logic [7:0]  gain_r;
    logic        one_shot;
  } voice_t;

endpackage

### rtl/pcm16_if.sv
interface pcm16_in_if
  import pcm16_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [REG_W-1:0]   reg_addr;
  logic [DATA_W-1:0]  write_data;
  logic [RADDR_W-1:0] ram_addr;

  modport source (output valid, mode, reg_addr, write_data, ram_addr, input ready);
  modport sink   (input valid, mode, reg_addr, write_data, ram_addr, output ready);
endinterface

interface pcm16_out_if
  import pcm16_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [DATA_W-1:0]        read_data;
  logic signed [SMP_W-1:0]  left_out;
  logic signed [SMP_W-1:0]  right_out;
  logic                     irq_stream;
  logic                     irq_timer;
  logic [MASK_W-1:0]        active_voices;

  modport source (output valid, read_data, left_out, right_out, irq_stream, irq_timer,
                  active_voices, input ready);
  modport sink   (input valid, read_data, left_out, right_out, irq_stream, irq_timer,
                  active_voices, output ready);
endinterface

### rtl/pcm_sound_chip_16_voice_core.sv
// Sixteen-voice 8-bit PCM sound chip. One result word per input word. After reset the
// block sweeps its 64 KiB sound RAM, register file and voice table to zero, one address
// a cycle, and takes no word until the sweep is done. Then register writes, chip-clock
// ticks and sound RAM writes finish straight from idle, register reads pass a read
// state, writes that touch a voice pass a voice read and a write-back state, and a
// sample tick walks the voices in order through the voice table and sound RAM ports: a
// read and a RAM state per voice, a mix state for a playing voice only, then a done
// state. One word is in work at a time; the next is taken once the result is taken.
`include "pcm_sound_chip_16_voice_core_defines.svh"

module pcm_sound_chip_16_voice_core
  import pcm16_pkg::*;
#(
  parameter int VOICES = 16,
  parameter int TIMER_STEP_CLOCKS = 10
) (
  input  logic clk,
  input  logic rst_n,
  pcm16_in_if.sink    in_ch,
  pcm16_out_if.source out_ch
);

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam logic [VW-1:0] LAST_V = VW'(VOICES - 1);
  localparam logic [6:0] STEP = 7'(TIMER_STEP_CLOCKS);

  typedef enum logic [2:0] {
    S_IDLE, S_REG_RD, S_VOICE_RD, S_VOICE_WB, S_TICK_RD, S_TICK_RAM, S_TICK_MIX, S_TICK_DONE
  } state_t;

  state_t state_r;

  logic [7:0]  ram_mem [65536];
  logic [7:0]  rf_mem [256];
  voice_t      v_mem [VOICES];

  logic [16:0] clr_cnt_r;
  logic        clr_done;
  logic [7:0]  ram_q_r;
  logic [7:0]  rf_q_r;
  voice_t      vq_r;
  logic [VW-1:0] vaddr;
  logic [VW-1:0] v_r;

  logic [REG_W-1:0]  reg_r;
  logic [DATA_W-1:0] data_r;

  logic [VOICES-1:0] mask_r;
  logic        timer_run_r;
  logic [19:0] timer_rem_r;
  logic        irq_stream_r;
  logic        irq_timer_r;
  logic [15:0] period_r;
  logic [7:0]  timer_ctrl_r;

  logic signed [21:0] acc_l_r, acc_r_r;
  logic        out_valid_r;
  logic [7:0]  rd_data_r;
  logic signed [15:0] left_r, right_r;

  logic        accept;
  logic [3:0]  grp;
  logic        in_ok;
  logic        key_ok;
  logic        voice_wr;
  logic [VW-1:0] in_idx;
  logic [23:0] load_prod;
  logic [19:0] timer_load;
  logic [19:0] rem_dec;

  // sample path
  logic signed [7:0]  smp;
  logic [22:0] phase;
  logic [15:0] pos_adv;
  logic signed [16:0] prod_l, prod_r;
  logic [15:0] key_pos;
  voice_t      v_tick_nxt;
  voice_t      v_reg_nxt;
  logic        tick_stop;
  logic        tick_stream;
  logic        v_playing;
  logic signed [17:0] mix_l, mix_r;
  logic signed [15:0] left_nxt, right_nxt;

  assign clr_done = clr_cnt_r[16];
  assign in_ch.ready = (state_r == S_IDLE) && clr_done && !out_valid_r;
  assign accept = in_ch.valid && in_ch.ready;

  assign grp = in_ch.reg_addr[7:4];
  assign in_ok = {1'b0, in_ch.reg_addr[3:0]} < 5'(VOICES);
  assign key_ok = {1'b0, in_ch.write_data[3:0]} < 5'(VOICES);
  always_comb begin
    voice_wr = 1'b0;
    if (in_ch.mode == MODE_REG_WR) begin
      case (grp)
        GRP_PITCH_LO, GRP_PITCH_HI, GRP_LENGTH, GRP_START_HI, GRP_START_LO, GRP_STREAM,
        GRP_VOLUME: voice_wr = in_ok;
        default:    voice_wr = (in_ch.reg_addr == REG_KEY) && key_ok &&
                               (in_ch.write_data[7:4] != 4'h0);
      endcase
    end
  end
  assign in_idx = (in_ch.reg_addr == REG_KEY) ? in_ch.write_data[VW-1:0]
                                              : in_ch.reg_addr[VW-1:0];

  assign load_prod = 24'(STEP) * 24'(17'h10000 - {1'b0, period_r});
  assign timer_load = load_prod[19:0];
  assign rem_dec = (timer_rem_r != 20'd0) ? timer_rem_r - 20'd1 : 20'd0;

  // memories
  assign vaddr = (state_r == S_IDLE) ? in_idx : v_r;

  always_ff @(posedge clk) begin
    ram_q_r <= ram_mem[vq_r.pos];
    if (!clr_done) begin
      ram_mem[clr_cnt_r[15:0]] <= 8'h00;
    end else if (accept && in_ch.mode == MODE_RAM_WR) begin
      ram_mem[in_ch.ram_addr] <= in_ch.write_data;
    end
  end

  always_ff @(posedge clk) begin
    rf_q_r <= rf_mem[in_ch.reg_addr];
    if (!clr_done) begin
      rf_mem[clr_cnt_r[7:0]] <= 8'h00;
    end else if (accept && in_ch.mode == MODE_REG_WR) begin
      rf_mem[in_ch.reg_addr] <= in_ch.write_data;
    end
  end

  always_ff @(posedge clk) begin
    vq_r <= v_mem[vaddr];
    if (!clr_done) begin
      if (clr_cnt_r < 17'(VOICES)) begin
        v_mem[clr_cnt_r[VW-1:0]] <= '0;
      end
    end else if (state_r == S_VOICE_WB) begin
      v_mem[v_r] <= v_reg_nxt;
    end else if (state_r == S_TICK_MIX) begin
      v_mem[v_r] <= v_tick_nxt;
    end
  end

  // register write into the voice entry
  always_comb begin
    v_reg_nxt = vq_r;
    if (reg_r == REG_KEY) begin
      v_reg_nxt.pos = {vq_r.start[9:0], 6'b0};
      v_reg_nxt.end_addr = {vq_r.start[9:0], 6'b0} + {2'b0, vq_r.length};
    end else begin
      case (reg_r[7:4])
        GRP_PITCH_LO: v_reg_nxt.pitch[7:0] = data_r;
        GRP_PITCH_HI: v_reg_nxt.pitch[15:8] = data_r;
        GRP_LENGTH: begin
          v_reg_nxt.length = 14'(14'h40 << data_r[3:1]);
          v_reg_nxt.one_shot = data_r[0];
        end
        GRP_START_HI: v_reg_nxt.start[15:8] = data_r;
        GRP_START_LO: v_reg_nxt.start[7:0] = data_r;
        GRP_STREAM:   v_reg_nxt.streaming = (data_r != 8'h00);
        GRP_VOLUME: begin
          v_reg_nxt.gain_l = {data_r[7:4], data_r[7:4]};
          v_reg_nxt.gain_r = {data_r[3:0], data_r[3:0]};
        end
        default: v_reg_nxt = vq_r;
      endcase
    end
  end

  // one voice step of the sample tick
  assign v_playing = mask_r[v_r];
  assign smp = $signed(ram_q_r ^ 8'h80);
  assign phase = {7'b0, vq_r.frac} + {1'b0, vq_r.pitch, 6'b0};
  assign pos_adv = vq_r.pos + {9'b0, phase[22:16]};
  assign prod_l = smp * $signed({1'b0, vq_r.gain_l});
  assign prod_r = smp * $signed({1'b0, vq_r.gain_r});
  assign key_pos = {vq_r.start[9:0], 6'b0};
  always_comb begin
    v_tick_nxt = vq_r;
    v_tick_nxt.frac = phase[15:0];
    v_tick_nxt.pos = pos_adv;
    tick_stop = 1'b0;
    tick_stream = 1'b0;
    if (pos_adv >= vq_r.end_addr) begin
      if (vq_r.streaming) begin
        tick_stream = 1'b1;
        v_tick_nxt.pos = key_pos;
        v_tick_nxt.end_addr = key_pos + {2'b0, vq_r.length};
      end else if (vq_r.one_shot) begin
        tick_stop = 1'b1;
      end else begin
        v_tick_nxt.pos = pos_adv - {2'b0, vq_r.length};
      end
    end
  end

  // floor by 16, then saturate
  assign mix_l = 18'(acc_l_r >>> 4);
  assign mix_r = 18'(acc_r_r >>> 4);
  assign left_nxt = (mix_l > 18'sd32767) ? 16'sh7fff :
                    (mix_l < -18'sd32768) ? 16'sh8000 : 16'(mix_l);
  assign right_nxt = (mix_r > 18'sd32767) ? 16'sh7fff :
                     (mix_r < -18'sd32768) ? 16'sh8000 : 16'(mix_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      clr_cnt_r    <= '0;
      mask_r       <= '0;
      timer_run_r  <= 1'b0;
      timer_rem_r  <= '0;
      irq_stream_r <= 1'b0;
      irq_timer_r  <= 1'b0;
      period_r     <= '0;
      timer_ctrl_r <= '0;
      out_valid_r  <= 1'b0;
      v_r          <= '0;
    end else begin
      if (!clr_done) begin
        clr_cnt_r <= clr_cnt_r + 17'd1;
      end
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            reg_r     <= in_ch.reg_addr;
            data_r    <= in_ch.write_data;
            // a sample tick walks the voices from the first one
            v_r       <= (in_ch.mode == MODE_SAMPLE) ? '0 : in_idx;
            rd_data_r <= 8'h00;
            left_r    <= '0;
            right_r   <= '0;
            acc_l_r   <= '0;
            acc_r_r   <= '0;
            case (in_ch.mode)
              MODE_REG_WR: begin
                if (in_ch.reg_addr == REG_PERIOD_LO) period_r[7:0] <= in_ch.write_data;
                if (in_ch.reg_addr == REG_PERIOD_HI) period_r[15:8] <= in_ch.write_data;
                if (in_ch.reg_addr == REG_TIMER) begin
                  timer_ctrl_r <= in_ch.write_data;
                  if (in_ch.write_data[7]) begin
                    timer_run_r <= 1'b1;
                    timer_rem_r <= timer_load;
                  end
                end
                if (in_ch.reg_addr == REG_KEY && key_ok && in_ch.write_data[7:4] == 4'h0) begin
                  mask_r[in_ch.write_data[VW-1:0]] <= 1'b0;
                end
                if (voice_wr) begin
                  state_r <= S_VOICE_RD;
                end else begin
                  out_valid_r <= 1'b1;
                end
              end
              MODE_REG_RD: begin
                if (in_ch.reg_addr == REG_TIMER) irq_timer_r <= 1'b0;
                else if (in_ch.reg_addr == REG_STREAM) irq_stream_r <= 1'b0;
                state_r <= S_REG_RD;
              end
              MODE_SAMPLE: begin
                state_r <= S_TICK_RD;
              end
              MODE_CLOCK: begin
                if (timer_run_r) begin
                  if (rem_dec == 20'd0) begin
                    if (timer_ctrl_r[6]) begin
                      irq_timer_r <= 1'b1;
                      timer_rem_r <= timer_load;
                    end else begin
                      timer_rem_r <= rem_dec;
                      timer_run_r <= 1'b0;
                    end
                  end else begin
                    timer_rem_r <= rem_dec;
                  end
                end
                out_valid_r <= 1'b1;
              end
              default: out_valid_r <= 1'b1;
            endcase
          end
        end
        S_REG_RD: begin
          rd_data_r   <= rf_q_r;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        S_VOICE_RD: state_r <= S_VOICE_WB;
        S_VOICE_WB: begin
          if (reg_r == REG_KEY) mask_r[v_r] <= 1'b1;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        S_TICK_RD: state_r <= S_TICK_RAM;
        S_TICK_RAM: begin
          if (v_playing) begin
            state_r <= S_TICK_MIX;
          end else if (v_r == LAST_V) begin
            state_r <= S_TICK_DONE;
          end else begin
            v_r <= v_r + 1'b1;
            state_r <= S_TICK_RD;
          end
        end
        S_TICK_MIX: begin
          acc_l_r <= acc_l_r + 22'(prod_l);
          acc_r_r <= acc_r_r + 22'(prod_r);
          if (tick_stream) irq_stream_r <= 1'b1;
          if (tick_stop) mask_r[v_r] <= 1'b0;
          if (v_r == LAST_V) begin
            state_r <= S_TICK_DONE;
          end else begin
            v_r <= v_r + 1'b1;
            state_r <= S_TICK_RD;
          end
        end
        S_TICK_DONE: begin
          left_r      <= left_nxt;
          right_r     <= right_nxt;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.read_data     = rd_data_r;
  assign out_ch.left_out      = left_r;
  assign out_ch.right_out     = right_r;
  assign out_ch.irq_stream    = irq_stream_r;
  assign out_ch.irq_timer     = irq_timer_r;
  assign out_ch.active_voices = MASK_W'(mask_r);

  `PCM16_ASSERT(a_no_accept_while_clearing, in_ch.ready |-> clr_done, "word taken during clear")
  `PCM16_ASSERT(a_one_word_in_flight, out_valid_r |-> !in_ch.ready, "word taken with result held")
  `PCM16_ASSERT(a_timer_read_clears, (accept && in_ch.mode == MODE_REG_RD && in_ch.reg_addr == REG_TIMER) |=> !irq_timer_r, "timer irq not cleared by read")
  `PCM16_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE && !out_valid_r), "not idle after reset")

endmodule
